// ----- rtl/mtp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mtp_pkg;

	localparam int OCTETS = 6;
	localparam int ADDR_W = 48;
	localparam int POS_W = 5;
	localparam logic [POS_W-1:0] TEXT_LEN = POS_W'(3 * OCTETS - 1);
	localparam logic [ADDR_W-1:0] USED_MASK = (OCTETS >= 6) ? {ADDR_W{1'b1}}
		: ((ADDR_W'(1) << (8 * OCTETS)) - ADDR_W'(1));

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_BCAST = 2'd3;

	typedef enum logic [1:0] {
		TK_DIGIT,
		TK_SEP,
		TK_END,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t kind;
		logic [3:0] nibble;
	} tok_t;

endpackage
`default_nettype wire

// ----- rtl/mac_address_text_parser.sv -----
// a nul item is first written into the token queue; the result is registered in the
// output stage when the parse stage pops that nul item from the queue
// throughput: one character item per cycle; a two-entry token queue separates
// the classifier from the parse state, and only a nul item waits while a result
// is stalled, so input stalls once that nul and one more item fill the queue
// reset: arst_n clears position, partial address, error flag, queue and output valid
`timescale 1ns / 1ps
`default_nettype none
module mac_address_text_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] text_char,
	output logic out_valid,
	input wire logic out_stall,
	output logic [47:0] address,
	output logic [1:0] status
);

	mtp_pkg::tok_t front_tok;
	mtp_pkg::tok_t q_tok;
	logic q_full;
	logic q_nonempty;
	logic q_pop;

	mtp_front u_front (
		.text_char(text_char),
		.tok(front_tok)
	);

	mtp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid),
		.push_tok(front_tok),
		.full(q_full),
		.pop(q_pop),
		.nonempty(q_nonempty),
		.pop_tok(q_tok)
	);

	mtp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.tok_valid(q_nonempty),
		.tok(q_tok),
		.tok_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.address(address),
		.status(status)
	);

	assign in_stall = q_full;

endmodule
`default_nettype wire

// ----- rtl/mtp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtp_front (
	input wire logic [7:0] text_char,
	output mtp_pkg::tok_t tok
);

	logic [7:0] d_off;
	logic [7:0] l_off;
	logic [7:0] u_off;

	assign d_off = text_char - mtp_pkg::CH_ZERO;
	assign l_off = text_char - mtp_pkg::CH_LA + 8'd10;
	assign u_off = text_char - mtp_pkg::CH_UA + 8'd10;

	always_comb begin
		tok.kind = mtp_pkg::TK_OTHER;
		tok.nibble = 4'd0;
		if (text_char == mtp_pkg::CH_NUL) begin
			tok.kind = mtp_pkg::TK_END;
		end else if (text_char == mtp_pkg::CH_COLON) begin
			tok.kind = mtp_pkg::TK_SEP;
		end else if (text_char >= mtp_pkg::CH_ZERO && text_char <= mtp_pkg::CH_NINE) begin
			tok.kind = mtp_pkg::TK_DIGIT;
			tok.nibble = d_off[3:0];
		end else if (text_char >= mtp_pkg::CH_LA && text_char <= mtp_pkg::CH_LF) begin
			tok.kind = mtp_pkg::TK_DIGIT;
			tok.nibble = l_off[3:0];
		end else if (text_char >= mtp_pkg::CH_UA && text_char <= mtp_pkg::CH_UF) begin
			tok.kind = mtp_pkg::TK_DIGIT;
			tok.nibble = u_off[3:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mtp_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtp_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire mtp_pkg::tok_t push_tok,
	output logic full,
	input wire logic pop,
	output logic nonempty,
	output mtp_pkg::tok_t pop_tok
);

	mtp_pkg::tok_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign pop_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mtp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtp_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic tok_valid,
	input wire mtp_pkg::tok_t tok,
	output logic tok_pop,
	output logic out_valid,
	input wire logic out_stall,
	output logic [mtp_pkg::ADDR_W-1:0] address,
	output logic [1:0] status
);

	logic [mtp_pkg::POS_W-1:0] pos_q;
	logic [1:0] phase_q;
	logic [mtp_pkg::ADDR_W-1:0] part_q;
	logic err_q;
	logic out_valid_q;
	logic [mtp_pkg::ADDR_W-1:0] address_q;
	logic [1:0] status_q;
	logic [mtp_pkg::ADDR_W-1:0] masked;
	logic [1:0] final_status;
	logic [mtp_pkg::ADDR_W-1:0] final_addr;

	// only a nul item has to wait for the output register
	assign tok_pop = tok_valid
		&& (tok.kind != mtp_pkg::TK_END || !out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign address = address_q;
	assign status = status_q;
	assign masked = part_q & mtp_pkg::USED_MASK;

	always_comb begin
		final_addr = masked;
		if (err_q || pos_q != mtp_pkg::TEXT_LEN) begin
			final_status = mtp_pkg::ST_BAD;
			final_addr = '0;
		end else if (masked == '0) begin
			final_status = mtp_pkg::ST_ZERO;
		end else if (masked == mtp_pkg::USED_MASK) begin
			final_status = mtp_pkg::ST_BCAST;
		end else begin
			final_status = mtp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop && tok.kind == mtp_pkg::TK_END) begin
			address_q <= final_addr;
			status_q <= final_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			phase_q <= 2'd0;
			part_q <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tok_pop && tok.kind == mtp_pkg::TK_END) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (tok_pop) begin
				if (tok.kind == mtp_pkg::TK_END) begin
					pos_q <= '0;
					phase_q <= 2'd0;
					part_q <= '0;
					err_q <= 1'b0;
				end else if (!err_q) begin
					if (pos_q == mtp_pkg::TEXT_LEN) begin
						err_q <= 1'b1;
					end else if (phase_q == 2'd2) begin
						// separator slot
						if (tok.kind != mtp_pkg::TK_SEP) begin
							err_q <= 1'b1;
						end else begin
							pos_q <= pos_q + mtp_pkg::POS_W'(1);
							phase_q <= 2'd0;
						end
					end else if (tok.kind != mtp_pkg::TK_DIGIT) begin
						err_q <= 1'b1;
					end else begin
						part_q <= {part_q[mtp_pkg::ADDR_W-5:0], tok.nibble};
						pos_q <= pos_q + mtp_pkg::POS_W'(1);
						phase_q <= phase_q + 2'd1;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mtp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [47:0] address,
	input wire logic [1:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(address) && $stable(status))
		else $error("result changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mtp_pkg::ST_BAD |-> address == 48'd0)
		else $error("bad format with nonzero address");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mtp_pkg::ST_ZERO |-> address == 48'd0)
		else $error("zero status with nonzero address");

	a_bcast_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mtp_pkg::ST_BCAST |-> address == mtp_pkg::USED_MASK)
		else $error("broadcast status with other address");

	a_ok_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mtp_pkg::ST_OK |->
		address != 48'd0 && address != mtp_pkg::USED_MASK)
		else $error("ok status with special address");

endmodule

bind mac_address_text_parser mtp_checker u_mtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.address(address),
	.status(status)
);
`default_nettype wire
